// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// Types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

	// Status codes carried on every result
	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_OK       = 3'd1,
		ST_NO_OPEN  = 3'd2,
		ST_ESC_CUT  = 3'd3,
		ST_BAD_ESC  = 3'd4,
		ST_HEX_CUT  = 3'd5,
		ST_BAD_HEX  = 3'd6,
		ST_UNCLOSED = 3'd7
	} status_t;

	// Source characters with special meaning
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	// Surrogate halves: top six bits of the 16-bit code
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// Most bytes one source byte can produce, and count width
	localparam int MAX_BYTES = 6;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BYTES);

	// Queue between decoder and byte emitter
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		status_t    status;
	} out_item_t;

	// One decoded source byte: its output bytes in order (index 0 first)
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		status_t                   status;
	} entry_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} utf8_t;

	// Hex digit value, bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Simple escape mapping, bit 8 set when the escape is known
	function automatic logic [8:0] simple_esc(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SLASH:  r = {1'b1, CH_SLASH};
			CH_B:      r = {1'b1, 8'h08};
			CH_F:      r = {1'b1, 8'h0C};
			CH_N:      r = {1'b1, 8'h0A};
			CH_R:      r = {1'b1, 8'h0D};
			CH_T:      r = {1'b1, 8'h09};
			default:   r = '0;
		endcase
		return r;
	endfunction

	// Code point to UTF-8, first byte in bytes[0]
	function automatic utf8_t utf8_encode(input logic [20:0] code);
		utf8_t r;
		r = '0;
		if (code < 21'h80) begin
			r.bytes[0] = code[7:0];
			r.n = 3'd1;
		end else if (code < 21'h800) begin
			r.bytes[0] = {3'b110, code[10:6]};
			r.bytes[1] = {2'b10, code[5:0]};
			r.n = 3'd2;
		end else if (code < 21'h10000) begin
			r.bytes[0] = {4'b1110, code[15:12]};
			r.bytes[1] = {2'b10, code[11:6]};
			r.bytes[2] = {2'b10, code[5:0]};
			r.n = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, code[20:18]};
			r.bytes[1] = {2'b10, code[17:12]};
			r.bytes[2] = {2'b10, code[11:6]};
			r.bytes[3] = {2'b10, code[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/json_string_unescape_utf8_top.sv =====
// JSON string unescaper: takes a quoted string one source byte per request, starting at the
// opening quote, and delivers the decoded bytes, with \u escapes and surrogate pairs turned
// into UTF-8. A source byte that yields no more than one output byte is taken every cycle while
// the result is not stalled; one that yields n bytes (up to six) holds the output while the
// emitter sends them one byte per cycle, and the two-entry queue between decoder and emitter
// then fills and stalls the source. A source byte's result passes the queue, then the output register.
// Each result carries the running status; once a final status is reached every later source
// request gives one result with no byte and that status, until reset.
`include "assert_macros.svh"

module json_string_unescape_utf8_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  jsu_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output jsu_pkg::out_item_t result
);
	import jsu_pkg::*;

	logic   accept, push, pop, q_full, q_empty;
	logic   res_nobyte, res_final;
	entry_t entry, head;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.entry  (entry)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Checks
	assign res_nobyte = result_valid && !result.byte_valid;
	assign res_final  = result.last && result.status != ST_RUN;

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_empty, "pop from empty queue")
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && q_full, "push into full queue")
	`ASSERT_IMPLY(a_nobyte_final, clk, arst_n, res_nobyte, res_final, "byteless result not final")

endmodule

// ===== hw/rtl/jsu_front.sv =====
// Decoder: tracks the string syntax and turns each source byte into a queue entry.
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  jsu_pkg::in_item_t item,
	output logic             push,
	output jsu_pkg::entry_t  entry
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_OPEN, PH_TEXT, PH_ESC, PH_HEX, PH_HIGH, PH_HIGHESC, PH_LOWHEX, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {SEC_NONE, SEC_RAW, SEC_CODE} sec_t;

	phase_t      phase_q, phase_d;
	status_t     done_st_q, st;
	logic [15:0] acc_q, acc_d, hh_q, hh_d, acc_new;
	logic [1:0]  dc_q, dc_d;
	logic        pre_en;
	sec_t        sec_kind;
	logic [7:0]  sec_raw;
	logic [20:0] sec_code;
	logic [4:0]  hx;
	logic [8:0]  es;
	logic [7:0]  b;
	logic        src_end;
	utf8_t       pre_enc, sec_enc, sec_b;

	assign b       = item.data_byte;
	assign src_end = item.end_marker;
	assign hx      = hex_digit(b);
	assign es      = simple_esc(b);
	assign acc_new = {acc_q[11:0], hx[3:0]};

	// Next state and what this request emits
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		hh_d     = hh_q;
		dc_d     = dc_q;
		st       = ST_RUN;
		pre_en   = 1'b0;
		sec_kind = SEC_NONE;
		sec_raw  = b;
		sec_code = {5'd0, acc_new};
		case (phase_q)
			PH_OPEN: begin
				if (!src_end && b == CH_QUOTE) phase_d = PH_TEXT;
				else st = ST_NO_OPEN;
			end
			PH_TEXT: begin
				if (src_end) st = ST_UNCLOSED;
				else if (b == CH_QUOTE) st = ST_OK;
				else if (b == CH_BSLASH) phase_d = PH_ESC;
				else sec_kind = SEC_RAW;
			end
			PH_ESC, PH_HIGHESC: begin
				if (src_end) begin
					st = ST_ESC_CUT;
					pre_en = (phase_q == PH_HIGHESC);
				end else if (b == CH_U) begin
					phase_d = (phase_q == PH_HIGHESC) ? PH_LOWHEX : PH_HEX;
					acc_d = '0;
					dc_d = '0;
				end else begin
					pre_en = (phase_q == PH_HIGHESC);
					if (es[8]) begin
						sec_kind = SEC_RAW;
						sec_raw = es[7:0];
						phase_d = PH_TEXT;
					end else begin
						st = ST_BAD_ESC;
					end
				end
			end
			PH_HEX, PH_LOWHEX: begin
				if (src_end) st = ST_HEX_CUT;
				else if (!hx[4]) st = ST_BAD_HEX;
				else begin
					acc_d = acc_new;
					if (dc_q != 2'd3) begin
						dc_d = dc_q + 2'd1;
					end else begin
						dc_d = '0;
						phase_d = PH_TEXT;
						if (phase_q == PH_HEX) begin
							if (acc_new[15:10] == SURR_HIGH) begin
								hh_d = acc_new;
								phase_d = PH_HIGH;
							end else begin
								sec_kind = SEC_CODE;
							end
						end else if (acc_new[15:10] == SURR_LOW) begin
							sec_kind = SEC_CODE;
							sec_code = SUPP_BASE + {1'b0, hh_q[9:0], acc_new[9:0]};
						end else begin
							pre_en = 1'b1;
							sec_kind = SEC_CODE;
						end
					end
				end
			end
			PH_HIGH: begin
				if (src_end) begin
					pre_en = 1'b1;
					st = ST_UNCLOSED;
				end else if (b == CH_BSLASH) begin
					phase_d = PH_HIGHESC;
				end else begin
					pre_en = 1'b1;
					phase_d = PH_TEXT;
					if (b == CH_QUOTE) st = ST_OK;
					else sec_kind = SEC_RAW;
				end
			end
			PH_DONE: st = done_st_q;
			default: st = done_st_q;
		endcase
		if (st != ST_RUN) phase_d = PH_DONE;
	end

	// Assemble the byte list: pending high surrogate first, then the second item
	assign pre_enc = utf8_encode({5'd0, hh_q});
	assign sec_enc = utf8_encode(sec_code);

	always_comb begin
		sec_b = '0;
		case (sec_kind)
			SEC_RAW: begin
				sec_b.bytes[0] = sec_raw;
				sec_b.n = 3'd1;
			end
			SEC_CODE: sec_b = sec_enc;
			default:  sec_b = '0;
		endcase
		entry = '0;
		entry.status = st;
		if (pre_en) begin
			entry.bytes[2:0] = pre_enc.bytes[2:0];
			entry.bytes[5:3] = sec_b.bytes[2:0];
			entry.cnt = CNT_W'(sec_b.n) + CNT_W'(3);
		end else begin
			entry.bytes[3:0] = sec_b.bytes;
			entry.cnt = CNT_W'(sec_b.n);
		end
	end

	assign push = accept && (entry.cnt != '0 || st != ST_RUN);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OPEN;
			done_st_q <= ST_RUN;
			acc_q     <= '0;
			hh_q      <= '0;
			dc_q      <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			hh_q    <= hh_d;
			dc_q    <= dc_d;
			if (st != ST_RUN) done_st_q <= st;
		end
	end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// Short entry queue between the decoder and the byte emitter.
module jsu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jsu_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output jsu_pkg::entry_t head,
	output logic            empty
);
	import jsu_pkg::*;

	entry_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// Byte emitter: walks the head entry one byte per cycle, while the result is not stalled, into the output register.
module jsu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jsu_pkg::entry_t    head,
	input  logic               empty,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output jsu_pkg::out_item_t result
);
	import jsu_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             ld, is_last, has_bytes;

	assign has_bytes = (head.cnt != '0);
	assign is_last   = !has_bytes || (CNT_W'(idx_q) + CNT_W'(1) == head.cnt);
	assign ld        = !empty && (!out_valid_q || !result_stall);
	assign pop       = ld && is_last;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Output payload
	always_ff @(posedge clk) begin
		if (ld) begin
			out_q.out_byte   <= has_bytes ? head.bytes[idx_q] : 8'd0;
			out_q.byte_valid <= has_bytes;
			out_q.last       <= is_last;
			out_q.status     <= head.status;
		end
	end

	// Output valid and byte index within the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (ld) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
			if (ld) idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule
